>>> rtl/core/fbsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsg_pkg
// Shared types and constants of the boot sector geometry unit.
// ----------------------------------------------------------------------------
package fbsg_pkg;

    // sector size and the counter that walks it
    localparam int SECTOR_BYTES = 512;
    localparam int SEC_SHIFT    = $clog2(SECTOR_BYTES);
    localparam int CNT_W        = SEC_SHIFT;

    // status codes, first failing check wins
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_EXFAT     = 4'd1;
    localparam logic [3:0] ST_SIGNATURE = 4'd2;
    localparam logic [3:0] ST_BPS       = 4'd3;
    localparam logic [3:0] ST_SPC       = 4'd4;
    localparam logic [3:0] ST_RESERVED  = 4'd5;
    localparam logic [3:0] ST_FAT_COUNT = 4'd6;
    localparam logic [3:0] ST_ZERO_SIZE = 4'd7;
    localparam logic [3:0] ST_LAYOUT    = 4'd8;
    localparam logic [3:0] ST_NO_CLUS   = 4'd9;
    localparam logic [3:0] ST_ROOT_REG  = 4'd10;
    localparam logic [3:0] ST_ROOT_CLUS = 4'd11;

    // fat type codes and the cluster count limits that pick them
    localparam logic [1:0]  FT_FAT12     = 2'd0;
    localparam logic [1:0]  FT_FAT16     = 2'd1;
    localparam logic [1:0]  FT_FAT32     = 2'd2;
    localparam logic [31:0] FAT12_LIMIT  = 32'd4085;
    localparam logic [31:0] FAT16_LIMIT  = 32'd65525;
    localparam logic [27:0] ROOT_CLUS_MIN = 28'd2;
    localparam logic [7:0]  SPC_MAX      = 8'd128;

    // boot signature bytes and the exfat oem name
    localparam logic [7:0] SIG_LO = 8'h55;
    localparam logic [7:0] SIG_HI = 8'hAA;
    localparam logic [7:0] EXFAT_NAME [8] = '{8'h45, 8'h58, 8'h46, 8'h41,
                                             8'h54, 8'h20, 8'h20, 8'h20};

    // input transaction payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       sector_start;
    } in_item_t;

    // result transaction payload
    typedef struct packed {
        logic [3:0]  status;
        logic [1:0]  fat_type;
        logic [7:0]  sectors_per_cluster;
        logic [7:0]  fat_count;
        logic [31:0] first_fat_lba;
        logic [31:0] first_root_lba;
        logic [31:0] first_data_lba;
        logic [31:0] cluster_count;
        logic [15:0] root_entry_count;
        logic [27:0] root_start_cluster;
        logic [31:0] fsinfo_sector;
    } out_item_t;

    // shared adder request and response
    typedef struct packed {
        logic [32:0] a;
        logic [32:0] b;
        logic        sub;
    } alu_req_t;

    typedef struct packed {
        logic [32:0] sum;
        logic        carry;
    } alu_rsp_t;

endpackage

>>> rtl/core/fat_boot_sector_geometry_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_boot_sector_geometry_unit
// Boot sector parser: captures the parameter block as the sector streams
// by and works out the volume geometry once the last byte is in.
// ----------------------------------------------------------------------------
// Usage
//   in_valid/in_ready carry one sector byte per transaction; sector_start
//   restarts the byte count, a partial sector gives no result.
//   out_valid/out_ready carry one result per complete sector.
//   cfg_wr_en/cfg_wr_data write the partition base LBA while idle.
// Timing
//   bytes are taken one per cycle while the sector streams in and in_ready
//   is high. After the last byte the sequencer runs its steps on one shared
//   33-bit adder: an early header failure ends them at the check, a good
//   FAT32 volume runs through all of them. in_ready is low during those
//   steps, so the next sector waits until they are done.
// Stall and reset
//   the result sits in an output register; the next sector streams in while
//   it waits, and only its last byte is held off until the result is taken.
//   reset clears the byte count, the partition base and out_valid.
// ----------------------------------------------------------------------------
module fat_boot_sector_geometry_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fbsg_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fbsg_pkg::out_item_t  out_data,
    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data
);
    import fbsg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_FFAT,
        S_FROOT,
        S_FDATA,
        S_USED,
        S_REM,
        S_TYPE,
        S_RC1,
        S_RC2,
        S_FSI
    } state_t;

    // byte offsets inside the sector
    localparam logic [CNT_W-1:0] LAST_POS   = CNT_W'(SECTOR_BYTES - 1);
    localparam logic [CNT_W-1:0] OFF_NAME   = CNT_W'(3);
    localparam logic [CNT_W-1:0] OFF_NAME_E = CNT_W'(10);
    localparam logic [CNT_W-1:0] OFF_TRAIL0 = CNT_W'(510);
    localparam logic [CNT_W-1:0] OFF_TRAIL1 = CNT_W'(511);

    state_t            state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [CNT_W-1:0]  pos;
    logic [2:0]        name_idx;
    logic              in_fire;
    logic              last_byte;
    logic [31:0]       base_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    // captured header fields
    logic [7:0]  match_reg;
    logic [15:0] bps_reg;
    logic [7:0]  spc_reg;
    logic [15:0] rsvd_reg;
    logic [7:0]  nfat_reg;
    logic [15:0] rootents_reg;
    logic [15:0] tot16_reg;
    logic [15:0] fsz16_reg;
    logic [31:0] tot32_reg;
    logic [31:0] fsz32_reg;
    logic [27:0] rclus_reg;
    logic [15:0] fsi16_reg;
    logic [7:0]  trail0_reg;
    logic [7:0]  trail1_reg;

    // sequencer working registers
    logic [31:0] ffat_reg;
    logic [31:0] froot_reg;
    logic [31:0] fdata_reg;
    logic [31:0] used_reg;
    logic [31:0] clus_reg;
    logic [32:0] tmp_reg;

    logic [31:0] total_sel;
    logic [31:0] fatsz_sel;
    logic [31:0] fat_span;
    logic [21:0] rs_sum;
    logic [32:0] rootsecs;
    logic [2:0]  spc_shift;
    logic [1:0]  type_sel;
    logic        spc_bad;
    logic [3:0]  chk_status;
    out_item_t   geom_item;
    alu_req_t    alu_req;
    alu_rsp_t    alu_rsp;

    // failed result: status only, geometry zero
    function automatic out_item_t fail_item(input logic [3:0] st);
        out_item_t r;
        r        = '0;
        r.status = st;
        return r;
    endfunction

    // byte position of the incoming transaction
    assign in_fire   = in_valid && in_ready;
    assign pos       = in_data.sector_start ? '0 : cnt_reg;
    assign last_byte = (pos == LAST_POS);
    assign cnt_next  = last_byte ? '0 : pos + CNT_W'(1);
    assign name_idx  = 3'(pos - OFF_NAME);

    // hold off only the last byte while a result still waits
    assign in_ready  = (state_reg == S_IDLE) && !(out_valid_reg && (cnt_reg == LAST_POS));
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // derived header values
    assign total_sel = (tot16_reg == 16'd0) ? tot32_reg : {16'd0, tot16_reg};
    assign fatsz_sel = (fsz16_reg == 16'd0) ? fsz32_reg : {16'd0, fsz16_reg};
    assign fat_span  = (nfat_reg == 8'd2) ? {fatsz_sel[30:0], 1'b0} : fatsz_sel;
    assign rs_sum    = {1'b0, rootents_reg, 5'd0} + 22'(SECTOR_BYTES - 1);
    assign rootsecs  = 33'(rs_sum >> SEC_SHIFT);
    assign spc_bad   = (spc_reg == 8'd0) || ((spc_reg & (spc_reg - 8'd1)) != 8'd0)
                       || (spc_reg > SPC_MAX);

    // log2 of sectors per cluster
    always_comb
    begin
        spc_shift = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (spc_reg[i])
            begin
                spc_shift = 3'(i);
            end
        end
    end

    // fat type from the cluster count
    always_comb
    begin
        if (clus_reg < FAT12_LIMIT)
        begin
            type_sel = FT_FAT12;
        end
        else if (clus_reg < FAT16_LIMIT)
        begin
            type_sel = FT_FAT16;
        end
        else
        begin
            type_sel = FT_FAT32;
        end
    end

    // header checks that need no arithmetic, first failure wins
    always_comb
    begin
        if (&match_reg)
        begin
            chk_status = ST_EXFAT;
        end
        else if ((trail0_reg != SIG_LO) || (trail1_reg != SIG_HI))
        begin
            chk_status = ST_SIGNATURE;
        end
        else if (bps_reg != 16'(SECTOR_BYTES))
        begin
            chk_status = ST_BPS;
        end
        else if (spc_bad)
        begin
            chk_status = ST_SPC;
        end
        else if (rsvd_reg == 16'd0)
        begin
            chk_status = ST_RESERVED;
        end
        else if ((nfat_reg != 8'd1) && (nfat_reg != 8'd2))
        begin
            chk_status = ST_FAT_COUNT;
        end
        else if ((total_sel == 32'd0) || (fatsz_sel == 32'd0))
        begin
            chk_status = ST_ZERO_SIZE;
        end
        else
        begin
            chk_status = ST_OK;
        end
    end

    // geometry of a good volume, root cluster and fsinfo filled in later
    always_comb
    begin
        geom_item                     = '0;
        geom_item.status              = ST_OK;
        geom_item.fat_type            = type_sel;
        geom_item.sectors_per_cluster = spc_reg;
        geom_item.fat_count           = nfat_reg;
        geom_item.first_fat_lba       = ffat_reg;
        geom_item.first_root_lba      = froot_reg;
        geom_item.first_data_lba      = fdata_reg;
        geom_item.cluster_count       = clus_reg;
        geom_item.root_entry_count    = rootents_reg;
    end

    // operand select for the shared adder
    always_comb
    begin
        alu_req = '0;
        unique case (state_reg)
            S_FFAT:
            begin
                alu_req.a = {1'b0, base_reg};
                alu_req.b = {17'd0, rsvd_reg};
            end
            S_FROOT:
            begin
                alu_req.a = {1'b0, ffat_reg};
                alu_req.b = {1'b0, fat_span};
            end
            S_FDATA:
            begin
                alu_req.a = {1'b0, froot_reg};
                alu_req.b = rootsecs;
            end
            S_USED:
            begin
                alu_req.a   = {1'b0, fdata_reg};
                alu_req.b   = {1'b0, base_reg};
                alu_req.sub = 1'b1;
            end
            S_REM:
            begin
                alu_req.a   = {1'b0, total_sel};
                alu_req.b   = {1'b0, used_reg};
                alu_req.sub = 1'b1;
            end
            S_RC1:
            begin
                alu_req.a = {1'b0, clus_reg};
                alu_req.b = 33'd1;
            end
            S_RC2:
            begin
                alu_req.a   = tmp_reg;
                alu_req.b   = {5'd0, rclus_reg};
                alu_req.sub = 1'b1;
            end
            S_FSI:
            begin
                alu_req.a = {1'b0, base_reg};
                alu_req.b = {17'd0, fsi16_reg};
            end
            default:
            begin
                alu_req = '0;
            end
        endcase
    end

    fbsg_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // header capture as the bytes stream by
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if ((pos >= OFF_NAME) && (pos <= OFF_NAME_E))
            begin
                match_reg[name_idx] <= (in_data.data_byte == EXFAT_NAME[name_idx]);
            end
            unique case (pos)
                CNT_W'(11):  bps_reg[7:0]        <= in_data.data_byte;
                CNT_W'(12):  bps_reg[15:8]       <= in_data.data_byte;
                CNT_W'(13):  spc_reg             <= in_data.data_byte;
                CNT_W'(14):  rsvd_reg[7:0]       <= in_data.data_byte;
                CNT_W'(15):  rsvd_reg[15:8]      <= in_data.data_byte;
                CNT_W'(16):  nfat_reg            <= in_data.data_byte;
                CNT_W'(17):  rootents_reg[7:0]   <= in_data.data_byte;
                CNT_W'(18):  rootents_reg[15:8]  <= in_data.data_byte;
                CNT_W'(19):  tot16_reg[7:0]      <= in_data.data_byte;
                CNT_W'(20):  tot16_reg[15:8]     <= in_data.data_byte;
                CNT_W'(22):  fsz16_reg[7:0]      <= in_data.data_byte;
                CNT_W'(23):  fsz16_reg[15:8]     <= in_data.data_byte;
                CNT_W'(32):  tot32_reg[7:0]      <= in_data.data_byte;
                CNT_W'(33):  tot32_reg[15:8]     <= in_data.data_byte;
                CNT_W'(34):  tot32_reg[23:16]    <= in_data.data_byte;
                CNT_W'(35):  tot32_reg[31:24]    <= in_data.data_byte;
                CNT_W'(36):  fsz32_reg[7:0]      <= in_data.data_byte;
                CNT_W'(37):  fsz32_reg[15:8]     <= in_data.data_byte;
                CNT_W'(38):  fsz32_reg[23:16]    <= in_data.data_byte;
                CNT_W'(39):  fsz32_reg[31:24]    <= in_data.data_byte;
                CNT_W'(44):  rclus_reg[7:0]      <= in_data.data_byte;
                CNT_W'(45):  rclus_reg[15:8]     <= in_data.data_byte;
                CNT_W'(46):  rclus_reg[23:16]    <= in_data.data_byte;
                CNT_W'(47):  rclus_reg[27:24]    <= in_data.data_byte[3:0];
                CNT_W'(48):  fsi16_reg[7:0]      <= in_data.data_byte;
                CNT_W'(49):  fsi16_reg[15:8]     <= in_data.data_byte;
                OFF_TRAIL0:  trail0_reg          <= in_data.data_byte;
                OFF_TRAIL1:  trail1_reg          <= in_data.data_byte;
                default:
                begin
                end
            endcase
        end
    end

    // byte count, configuration, sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data;
            end

            unique case (state_reg)
                // a result only waits while the sequencer is idle
                S_IDLE:
                begin
                    if (out_valid_reg && out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (in_fire)
                    begin
                        cnt_reg <= cnt_next;
                        if (last_byte)
                        begin
                            state_reg <= S_CHECK;
                        end
                    end
                end
                // early header failures end the sector here
                S_CHECK:
                begin
                    if (chk_status != ST_OK)
                    begin
                        out_data_reg  <= fail_item(chk_status);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_FFAT;
                    end
                end
                S_FFAT:
                begin
                    ffat_reg  <= alu_rsp.sum[31:0];
                    state_reg <= S_FROOT;
                end
                S_FROOT:
                begin
                    froot_reg <= alu_rsp.sum[31:0];
                    state_reg <= S_FDATA;
                end
                S_FDATA:
                begin
                    fdata_reg <= alu_rsp.sum[31:0];
                    state_reg <= S_USED;
                end
                // data start must lie above the base
                S_USED:
                begin
                    used_reg <= alu_rsp.sum[31:0];
                    if (!alu_rsp.carry || (alu_rsp.sum[31:0] == 32'd0))
                    begin
                        out_data_reg  <= fail_item(ST_LAYOUT);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_REM;
                    end
                end
                // data start must lie below the volume end
                S_REM:
                begin
                    clus_reg <= alu_rsp.sum[31:0] >> spc_shift;
                    if (!alu_rsp.carry || (alu_rsp.sum[31:0] == 32'd0))
                    begin
                        out_data_reg  <= fail_item(ST_LAYOUT);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_TYPE;
                    end
                end
                // cluster count and fat type
                S_TYPE:
                begin
                    if (clus_reg == 32'd0)
                    begin
                        out_data_reg  <= fail_item(ST_NO_CLUS);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else if ((type_sel == FT_FAT32) != (rootents_reg == 16'd0))
                    begin
                        out_data_reg  <= fail_item(ST_ROOT_REG);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        out_data_reg <= geom_item;
                        if (type_sel == FT_FAT32)
                        begin
                            state_reg <= S_RC1;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                end
                S_RC1:
                begin
                    tmp_reg   <= alu_rsp.sum;
                    state_reg <= S_RC2;
                end
                // root cluster within 2 .. clusters + 1
                S_RC2:
                begin
                    if ((rclus_reg < ROOT_CLUS_MIN) || !alu_rsp.carry)
                    begin
                        out_data_reg  <= fail_item(ST_ROOT_CLUS);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        out_data_reg.root_start_cluster <= rclus_reg;
                        state_reg                       <= S_FSI;
                    end
                end
                S_FSI:
                begin
                    out_data_reg.fsinfo_sector <= (fsi16_reg == 16'd0) ? 32'd0
                                                  : alu_rsp.sum[31:0];
                    out_valid_reg              <= 1'b1;
                    state_reg                  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/fbsg_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsg_alu
// Shared 33-bit add/subtract unit with carry out, used by every arithmetic
// step of the geometry sequencer.
// ----------------------------------------------------------------------------
module fbsg_alu
(
    input  fbsg_pkg::alu_req_t req,
    output fbsg_pkg::alu_rsp_t rsp
);
    import fbsg_pkg::*;

    logic [32:0] b_op;
    logic [33:0] total;

    // subtract as a plus inverted b plus one; carry set means no borrow
    assign b_op  = req.sub ? ~req.b : req.b;
    assign total = {1'b0, req.a} + {1'b0, b_op} + {33'd0, req.sub};

    assign rsp.sum   = total[32:0];
    assign rsp.carry = total[33];

endmodule

>>> rtl/core/fbsg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsg_checker
// Port-level checks on the geometry unit, attached by bind.
// ----------------------------------------------------------------------------
module fbsg_checker
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  fbsg_pkg::out_item_t  out_data
);
    import fbsg_pkg::*;

    // a stalled result transaction holds
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data);
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result changed while stalled");

    // only defined status codes appear
    property p_status_range;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status <= ST_ROOT_CLUS);
    endproperty
    a_status_range: assert property (p_status_range)
        else $error("undefined status code");

    // a failed sector carries no geometry
    property p_fail_zero;
        @(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != ST_OK) |->
            (out_data.fat_type == FT_FAT12) && (out_data.cluster_count == 32'd0)
            && (out_data.first_data_lba == 32'd0) && (out_data.fsinfo_sector == 32'd0)
            && (out_data.sectors_per_cluster == 8'd0) && (out_data.fat_count == 8'd0);
    endproperty
    a_fail_zero: assert property (p_fail_zero)
        else $error("geometry present on failed sector");

    // fat type agrees with the cluster count
    property p_type_match;
        @(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_OK) |->
            ((out_data.fat_type == FT_FAT12) == (out_data.cluster_count < FAT12_LIMIT))
            && ((out_data.fat_type == FT_FAT32) == (out_data.cluster_count >= FAT16_LIMIT))
            && (out_data.cluster_count != 32'd0);
    endproperty
    a_type_match: assert property (p_type_match)
        else $error("fat type does not match cluster count");

    // a good sector has a valid cluster size, fat count and root layout
    property p_ok_fields;
        @(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_OK) |->
            $onehot(out_data.sectors_per_cluster)
            && ((out_data.fat_count == 8'd1) || (out_data.fat_count == 8'd2))
            && ((out_data.fat_type == FT_FAT32) == (out_data.root_entry_count == 16'd0));
    endproperty
    a_ok_fields: assert property (p_ok_fields)
        else $error("inconsistent fields on good sector");

endmodule

bind fat_boot_sector_geometry_unit fbsg_checker u_fbsg_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the boot sector geometry unit. Sectors are streamed
// in one byte per transaction: first a stimulus table of directed sectors,
// then random well-formed, mutated, noisy and truncated sectors. A local
// geometry model or the table row gives each result and the monitor checks each field.
// ----------------------------------------------------------------------------
module tb;
    import fbsg_pkg::*;

    localparam int HDR_BYTES       = 52;
    localparam int DIR_ENTRY_BYTES = 32;
    localparam int CYCLE_LIMIT     = 3_000_000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int LONG_HOLD       = 1500;
    localparam int RANDOM_SECTORS  = 48;
    localparam int PHASE_SECTORS   = 8;
    localparam int HOLD_SECTOR     = 20;

    // idle modes shared by sender and receiver
    localparam int IDLE_NONE  = 0;
    localparam int IDLE_LIGHT = 1;
    localparam int IDLE_HEAVY = 2;

    // boot sector fields that a stimulus row sets
    typedef struct packed {
        bit          exfat;
        logic [15:0] bps;
        logic [7:0]  spc;
        logic [15:0] rsvd;
        logic [7:0]  nfat;
        logic [15:0] rootents;
        logic [15:0] tot16;
        logic [15:0] fatsz16;
        logic [31:0] tot32;
        logic [31:0] fatsz32;
        logic [31:0] rootclus;
        logic [15:0] fsinfo;
        logic [7:0]  sig0;
        logic [7:0]  sig1;
    } geom_t;

    typedef struct {
        geom_t       g;
        logic [31:0] base;
        bit          start;
        int          len;
        bit          typed;
        logic [3:0]  status;
    } plan_row_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    in_item_t    in_data     = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    out_item_t   out_data;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    // geometry model state
    logic [31:0] geo_base = '0;
    int          byte_pos = 0;
    logic [7:0]  hdr_copy [HDR_BYTES];
    logic [7:0]  sig_copy [2];

    out_item_t   geometry_due [$];
    plan_row_t   sector_plan [$];
    logic [7:0]  sector_buf [SECTOR_BYTES];
    bit          typed_pending = 1'b0;
    out_item_t   typed_result  = '0;
    int          idle_mode     = IDLE_NONE;
    bit          hold_request  = 1'b0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;

    fat_boot_sector_geometry_unit dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL fat_boot_sector_geometry_unit");
        $finish;
    end

    // ------------------------------------------------------------------------
    // geometry model
    // ------------------------------------------------------------------------
    function automatic logic [31:0] hdr16(int off);
        return {16'h0, hdr_copy[off + 1], hdr_copy[off]};
    endfunction

    function automatic logic [31:0] hdr32(int off);
        return {hdr_copy[off + 3], hdr_copy[off + 2], hdr_copy[off + 1], hdr_copy[off]};
    endfunction

    function automatic out_item_t predict_geometry();
        out_item_t   r;
        logic [31:0] spc, rsvd, nfat, rents, total, fatsz, rsecs;
        logic [31:0] ffat, froot, fdata, used, clus, rclus, fsi;
        logic [1:0]  ft;
        bit          exf;
        int          sh;
        r = '0;
        exf = 1'b1;
        for (int i = 0; i < 8; i++)
            if (hdr_copy[3 + i] != EXFAT_NAME[i])
                exf = 1'b0;
        // header checks, first failure wins
        if (exf)
        begin
            r.status = ST_EXFAT;
            return r;
        end
        if (sig_copy[0] != SIG_LO || sig_copy[1] != SIG_HI)
        begin
            r.status = ST_SIGNATURE;
            return r;
        end
        if (hdr16(11) != SECTOR_BYTES)
        begin
            r.status = ST_BPS;
            return r;
        end
        spc = {24'h0, hdr_copy[13]};
        if (spc == 0 || (spc & (spc - 1)) != 0 || spc > SPC_MAX)
        begin
            r.status = ST_SPC;
            return r;
        end
        rsvd = hdr16(14);
        if (rsvd == 0)
        begin
            r.status = ST_RESERVED;
            return r;
        end
        nfat = {24'h0, hdr_copy[16]};
        if (nfat < 1 || nfat > 2)
        begin
            r.status = ST_FAT_COUNT;
            return r;
        end
        rents = hdr16(17);
        total = hdr16(19);
        if (total == 0)
            total = hdr32(32);
        fatsz = hdr16(22);
        if (fatsz == 0)
            fatsz = hdr32(36);
        if (total == 0 || fatsz == 0)
        begin
            r.status = ST_ZERO_SIZE;
            return r;
        end
        // layout with 32-bit wrap
        rsecs = (rents * DIR_ENTRY_BYTES + SECTOR_BYTES - 1) / SECTOR_BYTES;
        ffat  = geo_base + rsvd;
        froot = ffat + fatsz * nfat;
        fdata = froot + rsecs;
        if (fdata <= geo_base || fdata - geo_base >= total)
        begin
            r.status = ST_LAYOUT;
            return r;
        end
        used = fdata - geo_base;
        sh = 0;
        while (sh < 7 && (32'd1 << sh) != spc)
            sh++;
        clus = (total - used) >> sh;
        if (clus == 0)
        begin
            r.status = ST_NO_CLUS;
            return r;
        end
        // type from cluster count and root checks
        ft = (clus < FAT12_LIMIT) ? FT_FAT12 : ((clus < FAT16_LIMIT) ? FT_FAT16 : FT_FAT32);
        rclus = '0;
        fsi   = '0;
        if (ft == FT_FAT32)
        begin
            if (rents != 0)
            begin
                r.status = ST_ROOT_REG;
                return r;
            end
            rclus = hdr32(44) & 32'h0FFF_FFFF;
            if (rclus < ROOT_CLUS_MIN || {1'b0, rclus} > {1'b0, clus} + 33'd1)
            begin
                r.status = ST_ROOT_CLUS;
                return r;
            end
            fsi = hdr16(48);
            if (fsi != 0)
                fsi = geo_base + fsi;
        end
        else if (rents == 0)
        begin
            r.status = ST_ROOT_REG;
            return r;
        end
        r.status              = ST_OK;
        r.fat_type            = ft;
        r.sectors_per_cluster = spc[7:0];
        r.fat_count           = nfat[7:0];
        r.first_fat_lba       = ffat;
        r.first_root_lba      = froot;
        r.first_data_lba      = fdata;
        r.cluster_count       = clus;
        r.root_entry_count    = rents[15:0];
        r.root_start_cluster  = rclus[27:0];
        r.fsinfo_sector       = fsi;
        return r;
    endfunction

    // follow one accepted byte, queue a result at the end of a sector
    task automatic track_byte(logic [7:0] b, logic s);
        out_item_t r;
        if (s)
            byte_pos = 0;
        if (byte_pos < HDR_BYTES)
            hdr_copy[byte_pos] = b;
        if (byte_pos == SECTOR_BYTES - 2)
            sig_copy[0] = b;
        if (byte_pos == SECTOR_BYTES - 1)
            sig_copy[1] = b;
        if (byte_pos + 1 < SECTOR_BYTES)
            byte_pos++;
        else
        begin
            byte_pos = 0;
            r = predict_geometry();
            if (typed_pending)
            begin
                r = typed_result;
                typed_pending = 1'b0;
            end
            geometry_due.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] seen);
        $display("mismatch %s: expected %h got %h", what, want, seen);
        mismatch_count++;
    endtask

    task automatic check_geometry(out_item_t seen);
        out_item_t want;
        if (geometry_due.size() == 0)
            flag_mismatch("result with nothing due", '0, {28'h0, seen.status});
        else
        begin
            want = geometry_due.pop_front();
            if (seen.status !== want.status)
                flag_mismatch("status", want.status, seen.status);
            if (seen.fat_type !== want.fat_type)
                flag_mismatch("fat_type", want.fat_type, seen.fat_type);
            if (seen.sectors_per_cluster !== want.sectors_per_cluster)
                flag_mismatch("sectors_per_cluster", want.sectors_per_cluster,
                              seen.sectors_per_cluster);
            if (seen.fat_count !== want.fat_count)
                flag_mismatch("fat_count", want.fat_count, seen.fat_count);
            if (seen.first_fat_lba !== want.first_fat_lba)
                flag_mismatch("first_fat_lba", want.first_fat_lba, seen.first_fat_lba);
            if (seen.first_root_lba !== want.first_root_lba)
                flag_mismatch("first_root_lba", want.first_root_lba, seen.first_root_lba);
            if (seen.first_data_lba !== want.first_data_lba)
                flag_mismatch("first_data_lba", want.first_data_lba, seen.first_data_lba);
            if (seen.cluster_count !== want.cluster_count)
                flag_mismatch("cluster_count", want.cluster_count, seen.cluster_count);
            if (seen.root_entry_count !== want.root_entry_count)
                flag_mismatch("root_entry_count", want.root_entry_count,
                              seen.root_entry_count);
            if (seen.root_start_cluster !== want.root_start_cluster)
                flag_mismatch("root_start_cluster", want.root_start_cluster,
                              seen.root_start_cluster);
            if (seen.fsinfo_sector !== want.fsinfo_sector)
                flag_mismatch("fsinfo_sector", want.fsinfo_sector, seen.fsinfo_sector);
        end
    endtask

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_geometry(out_data);
    end

    // ------------------------------------------------------------------------
    // idling
    // ------------------------------------------------------------------------
    function automatic int draw_idle();
        case (idle_mode)
            IDLE_NONE:  return 0;
            IDLE_LIGHT: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
            default:    return $urandom_range(0, 16);
        endcase
    endfunction

    // receiver, with one long hold-off on request
    initial
    begin
        int w;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                w = LONG_HOLD;
            end
            else
                w = draw_idle();
            if (w > 0)
            begin
                out_ready <= 1'b0;
                repeat (w) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // ------------------------------------------------------------------------
    // sector building and driving
    // ------------------------------------------------------------------------
    function automatic geom_t geom(logic [15:0] bps, logic [7:0] spc, logic [15:0] rsvd,
                                   logic [7:0] nfat, logic [15:0] rootents,
                                   logic [15:0] tot16, logic [15:0] fatsz16,
                                   logic [31:0] tot32, logic [31:0] fatsz32,
                                   logic [31:0] rootclus, logic [15:0] fsinfo);
        geom_t g;
        g.exfat    = 1'b0;
        g.bps      = bps;
        g.spc      = spc;
        g.rsvd     = rsvd;
        g.nfat     = nfat;
        g.rootents = rootents;
        g.tot16    = tot16;
        g.fatsz16  = fatsz16;
        g.tot32    = tot32;
        g.fatsz32  = fatsz32;
        g.rootclus = rootclus;
        g.fsinfo   = fsinfo;
        g.sig0     = SIG_LO;
        g.sig1     = SIG_HI;
        return g;
    endfunction

    task automatic put_le(int off, int n, logic [31:0] v);
        for (int i = 0; i < n; i++)
            sector_buf[off + i] = v[8 * i +: 8];
    endtask

    // random filler with the parameter block laid over it
    task automatic fill_sector(geom_t g);
        for (int i = 0; i < SECTOR_BYTES; i++)
            sector_buf[i] = 8'($urandom_range(0, 255));
        if (g.exfat)
            for (int i = 0; i < 8; i++)
                sector_buf[3 + i] = EXFAT_NAME[i];
        put_le(11, 2, {16'h0, g.bps});
        sector_buf[13] = g.spc;
        put_le(14, 2, {16'h0, g.rsvd});
        sector_buf[16] = g.nfat;
        put_le(17, 2, {16'h0, g.rootents});
        put_le(19, 2, {16'h0, g.tot16});
        put_le(22, 2, {16'h0, g.fatsz16});
        put_le(32, 4, g.tot32);
        put_le(36, 4, g.fatsz32);
        put_le(44, 4, g.rootclus);
        put_le(48, 2, {16'h0, g.fsinfo});
        sector_buf[SECTOR_BYTES - 2] = g.sig0;
        sector_buf[SECTOR_BYTES - 1] = g.sig1;
    endtask

    // well-formed volume of a random type with random content
    function automatic geom_t gen_geom();
        geom_t       g;
        int          t;
        logic [31:0] spc, rsvd, nfat, rents, fatsz, used, c, total;
        t     = $urandom_range(0, 2);
        spc   = 32'd1 << $urandom_range(0, 7);
        rsvd  = (t == 2) ? $urandom_range(1, 64) : $urandom_range(1, 8);
        nfat  = $urandom_range(1, 2);
        rents = (t == 2) ? 0 : (($urandom_range(0, 15) == 0) ? 32'hFFFF
                                                              : $urandom_range(1, 1024));
        fatsz = (t == 2) ? $urandom_range(1, 20000) : $urandom_range(1, 256);
        used  = rsvd + fatsz * nfat + (rents * DIR_ENTRY_BYTES + SECTOR_BYTES - 1) / SECTOR_BYTES;
        // cluster count, now and then right at a type boundary
        case (t)
            0:       c = $urandom_range(1, 4084);
            1:       c = $urandom_range(4085, 65524);
            default: c = $urandom_range(65525, 2000000);
        endcase
        if ($urandom_range(0, 7) == 0)
            case (t)
                0:       c = $urandom_range(0, 1) ? 1 : 4084;
                1:       c = $urandom_range(0, 1) ? 4085 : 65524;
                default: c = 65525;
            endcase
        total = used + c * spc + $urandom_range(0, spc - 1);
        g = geom(SECTOR_BYTES, spc[7:0], rsvd[15:0], nfat[7:0], rents[15:0],
                 16'h0, 16'h0, total, fatsz, $urandom, 16'($urandom_range(0, 65535)));
        if (total < 65536 && $urandom_range(0, 1))
            g.tot16 = total[15:0];
        if (t != 2 && $urandom_range(0, 1))
            g.fatsz16 = fatsz[15:0];
        if (t == 2)
        begin
            g.rootclus = {4'($urandom_range(0, 15)), 28'($urandom_range(2, c + 1))};
            if ($urandom_range(0, 1))
                g.fsinfo = '0;
        end
        return g;
    endfunction

    // one byte transaction, after a random gap
    task automatic send_byte(logic [7:0] b, logic s);
        int gap;
        gap = draw_idle();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {b, s};
        do @(posedge clk); while (!in_ready);
        track_byte(b, s);
    endtask

    task automatic send_sector(bit start, int len, bit noisy);
        logic s;
        for (int i = 0; i < len; i++)
        begin
            s = (i == 0) ? start : (noisy && $urandom_range(0, 63) == 0);
            send_byte(sector_buf[i], s);
        end
    endtask

    // pause until every result is in and the block has settled
    task automatic wait_geometry_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (geometry_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic program_base(logic [31:0] v);
        wait_geometry_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        geo_base = v;
    endtask

    task automatic add_row(geom_t g, logic [31:0] base, bit start, int len,
                           bit typed, logic [3:0] status);
        plan_row_t r;
        r.g      = g;
        r.base   = base;
        r.start  = start;
        r.len    = len;
        r.typed  = typed;
        r.status = status;
        sector_plan.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        geom_t       g12, g16, g32, g;
        plan_row_t   row;
        int          kind, len;
        bit          start, noisy, last_cut;
        logic [31:0] base;

        for (int i = 0; i < HDR_BYTES; i++)
            hdr_copy[i] = '0;
        sig_copy[0] = '0;
        sig_copy[1] = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        g12 = geom(SECTOR_BYTES, 8'd1, 16'd1, 8'd2, 16'd224, 16'd2880, 16'd9,
                   32'd0, 32'd0, 32'd0, 16'd0);
        g16 = geom(SECTOR_BYTES, 8'd4, 16'd1, 8'd2, 16'd512, 16'd0, 16'd200,
                   32'd200000, 32'd0, 32'd0, 16'd0);
        g32 = geom(SECTOR_BYTES, 8'd8, 16'd32, 8'd2, 16'd0, 16'd0, 16'd0,
                   32'h0010_0000, 32'd1024, 32'd2, 16'd1);

        // stimulus table: good volumes first
        add_row(g12, 32'h0, 1'b1, SECTOR_BYTES, 1'b0, ST_OK);
        add_row(g16, 32'h0, 1'b0, SECTOR_BYTES, 1'b0, ST_OK);    // count wraps, no start
        add_row(g32, 32'd2048, 1'b1, SECTOR_BYTES, 1'b0, ST_OK);
        g = g32; g.rootclus = 32'hF000_0002; g.fsinfo = '0;      // masked root cluster
        add_row(g, 32'd2048, 1'b1, SECTOR_BYTES, 1'b0, ST_OK);
        g = g12; g.spc = SPC_MAX; g.rootents = 16'hFFFF; g.tot16 = 16'hFFFF;
        add_row(g, 32'd2048, 1'b1, SECTOR_BYTES, 1'b0, ST_OK);
        // top base wraps the layout
        add_row(g32, 32'hFFFF_FFFF, 1'b1, SECTOR_BYTES, 1'b1, ST_LAYOUT);
        // early header failures
        g = g16; g.exfat = 1'b1;
        add_row(g, 32'hFFFF_FFFF, 1'b1, SECTOR_BYTES, 1'b1, ST_EXFAT);
        g = g16; g.sig0 = 8'h54;
        add_row(g, 32'hFFFF_FFFF, 1'b1, SECTOR_BYTES, 1'b1, ST_SIGNATURE);
        g = g16; g.sig0 = SIG_HI; g.sig1 = SIG_LO;
        add_row(g, 32'hFFFF_FFFF, 1'b1, SECTOR_BYTES, 1'b1, ST_SIGNATURE);
        g = g16; g.bps = 16'd1024;
        add_row(g, 32'hFFFF_FFFF, 1'b1, SECTOR_BYTES, 1'b1, ST_BPS);
        g = g16; g.bps = 16'hFFFF;
        add_row(g, 32'hFFFF_FFFF, 1'b1, SECTOR_BYTES, 1'b1, ST_BPS);
        g = g16; g.spc = 8'd0;
        add_row(g, 32'hFFFF_FFFF, 1'b1, SECTOR_BYTES, 1'b1, ST_SPC);
        g = g16; g.spc = 8'hFF;
        add_row(g, 32'hFFFF_FFFF, 1'b1, SECTOR_BYTES, 1'b1, ST_SPC);
        g = g16; g.rsvd = 16'd0;
        add_row(g, 32'hFFFF_FFFF, 1'b1, SECTOR_BYTES, 1'b1, ST_RESERVED);
        g = g16; g.nfat = 8'd0;
        add_row(g, 32'hFFFF_FFFF, 1'b1, SECTOR_BYTES, 1'b1, ST_FAT_COUNT);
        g = g16; g.nfat = 8'hFF;
        add_row(g, 32'hFFFF_FFFF, 1'b1, SECTOR_BYTES, 1'b1, ST_FAT_COUNT);
        g = g16; g.tot32 = 32'd0;
        add_row(g, 32'hFFFF_FFFF, 1'b1, SECTOR_BYTES, 1'b1, ST_ZERO_SIZE);
        // layout and cluster failures at base zero
        g = g12; g.tot16 = 16'd20;
        add_row(g, 32'h0, 1'b1, SECTOR_BYTES, 1'b1, ST_LAYOUT);
        g = g12; g.spc = 8'd2; g.tot16 = 16'd34;
        add_row(g, 32'h0, 1'b1, SECTOR_BYTES, 1'b1, ST_NO_CLUS);
        g = g32; g.rootents = 16'd16;
        add_row(g, 32'h0, 1'b1, SECTOR_BYTES, 1'b1, ST_ROOT_REG);
        g = g16; g.rootents = 16'd0;
        add_row(g, 32'h0, 1'b1, SECTOR_BYTES, 1'b1, ST_ROOT_REG);
        g = g32; g.rootclus = 32'd1;
        add_row(g, 32'h0, 1'b1, SECTOR_BYTES, 1'b1, ST_ROOT_CLUS);
        g = g32; g.rootclus = 32'h0FFF_FFFF;
        add_row(g, 32'h0, 1'b1, SECTOR_BYTES, 1'b1, ST_ROOT_CLUS);
        // sectors cut short by a new start
        add_row(g16, 32'h0, 1'b1, 100, 1'b0, ST_OK);
        add_row(g16, 32'h0, 1'b1, SECTOR_BYTES - 1, 1'b0, ST_OK);
        add_row(g16, 32'h0, 1'b1, SECTOR_BYTES, 1'b0, ST_OK);

        // walk the table
        for (int i = 0; i < sector_plan.size(); i++)
        begin
            row = sector_plan[i];
            if (i == 0 || row.base != geo_base)
                program_base(row.base);
            idle_mode = i % 3;
            fill_sector(row.g);
            typed_pending = row.typed;
            typed_result = '0;
            typed_result.status = row.status;
            send_sector(row.start, row.len, 1'b0);
        end

        // random sectors in phases of one base each
        last_cut = 1'b0;
        for (int k = 0; k < RANDOM_SECTORS; k++)
        begin
            if (k % PHASE_SECTORS == 0)
            begin
                case ($urandom_range(0, 4))
                    0:       base = 32'h0;
                    1:       base = 32'hFFFF_FFFF;
                    2:       base = $urandom;
                    3:       base = $urandom_range(0, 1 << 20);
                    default: base = 32'hFFFF_FFFF - $urandom_range(0, 1 << 24);
                endcase
                program_base(base);
            end
            case ($urandom_range(0, 7))
                0, 1, 2:    idle_mode = IDLE_NONE;
                7:          idle_mode = IDLE_HEAVY;
                default:    idle_mode = IDLE_LIGHT;
            endcase
            // receiver holds off while two sectors stream in back to back
            if (k == HOLD_SECTOR)
                hold_request = 1'b1;
            if (k == HOLD_SECTOR || k == HOLD_SECTOR + 1)
                idle_mode = IDLE_NONE;

            g = gen_geom();
            kind  = (k == HOLD_SECTOR || k == HOLD_SECTOR + 1) ? 19 : $urandom_range(0, 19);
            len   = SECTOR_BYTES;
            noisy = 1'b0;
            case (kind)
                0, 1:
                begin
                    // noise with random start marks
                    noisy = 1'b1;
                    if ($urandom_range(0, 1))
                    begin
                        g.sig0 = 8'($urandom_range(0, 255));
                        g.sig1 = 8'($urandom_range(0, 255));
                    end
                end
                2, 3:
                    len = $urandom_range(1, SECTOR_BYTES - 1);
                4, 5, 6, 7, 8:
                    // one broken field
                    case ($urandom_range(0, 9))
                        0: g.exfat = 1'b1;
                        1: g.sig0 = 8'($urandom_range(0, 255));
                        2: g.sig1 = 8'($urandom_range(0, 255));
                        3: g.bps = 16'($urandom_range(0, 65535));
                        4: g.spc = 8'($urandom_range(0, 255));
                        5: g.rsvd = 16'd0;
                        6: g.nfat = 8'($urandom_range(0, 255));
                        7:
                        begin
                            g.fatsz16 = 16'd0;
                            g.fatsz32 = 32'd0;
                        end
                        8: g.rootents = 16'($urandom_range(0, 65535));
                        default: g.rootclus = $urandom;
                    endcase
                default: ;
            endcase
            fill_sector(g);
            if (noisy)
                for (int i = 0; i < HDR_BYTES; i++)
                    sector_buf[i] = 8'($urandom_range(0, 255));
            start = last_cut ? ($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 1));
            send_sector(start, len, noisy);
            last_cut = (len != SECTOR_BYTES) || noisy;
        end

        wait_geometry_drained();
        if (mismatch_count == 0)
            $display("PASS fat_boot_sector_geometry_unit");
        else
            $display("FAIL fat_boot_sector_geometry_unit");
        $finish;
    end

endmodule
